// ===== src/grbf_pkg.sv =====
// ----------------------------------------------------------------------------
// grbf_pkg: shared types and constants
// Constants, state type and exp factor table for the Gaussian RBF kernel unit.
// ----------------------------------------------------------------------------
package grbf_pkg;

    localparam int GAMMA_W     = 24;
    localparam int KERNEL_W    = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int EXP_STEPS   = 20;
    localparam int T_W         = 20;
    localparam int P_W         = 25;
    localparam int FACTOR_W    = 24;
    localparam int STEP_CNT_W  = 5;
    localparam int CHUNK_W     = 16;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd32768;
    localparam logic [P_W-1:0]     Q24_ONE     = 25'd16777216;
    localparam logic [0:0]         REG_GAMMA   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_EXP,
        S_FIN,
        S_OUT
    } t_back_state;

    // round(2^24 * exp(-w)), w = 8, 4, 2, 1, 1/2 ... 1/65536
    function automatic logic [FACTOR_W-1:0] exp_factor(input logic [STEP_CNT_W-1:0] k);
        logic [FACTOR_W-1:0] f;
        case (k)
            5'd0:    f = 24'd5628;
            5'd1:    f = 24'd307285;
            5'd2:    f = 24'd2270549;
            5'd3:    f = 24'd6171993;
            5'd4:    f = 24'd10175896;
            5'd5:    f = 24'd13066109;
            5'd6:    f = 24'd14805841;
            5'd7:    f = 24'd15760736;
            5'd8:    f = 24'd16261035;
            5'd9:    f = 24'd16517109;
            5'd10:   f = 24'd16646655;
            5'd11:   f = 24'd16711808;
            5'd12:   f = 24'd16744480;
            5'd13:   f = 24'd16760840;
            5'd14:   f = 24'd16769026;
            5'd15:   f = 24'd16773120;
            5'd16:   f = 24'd16775168;
            5'd17:   f = 24'd16776192;
            5'd18:   f = 24'd16776704;
            5'd19:   f = 24'd16776960;
            default: f = 24'd16777215;
        endcase
        return f;
    endfunction

endpackage

// ===== src/grbf_if.sv =====
// ----------------------------------------------------------------------------
// grbf_if: item channels
// Valid/ready channels for element pairs and kernel results.
// ----------------------------------------------------------------------------
interface grbf_in_if #(
    parameter int ELEM_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] a_elem;
    logic signed [ELEM_BITS-1:0] b_elem;
    logic                        last;

    modport source (output valid, output a_elem, output b_elem, output last, input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface

interface grbf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] kernel_value;
    logic        saturated;

    modport source (output valid, output kernel_value, output saturated, input ready);
    modport sink   (input valid, input kernel_value, input saturated, output ready);
endinterface

// ===== src/gaussian_rbf_kernel_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_rbf_kernel_unit: Gaussian RBF kernel, one element pair per item
// Front accumulates squared differences at one item per cycle unless the job
// queue is full at a vector end; the back evaluates exp(-sum * gamma) per vector.
// Path: square register, job queue, then back states MUL, SCALE, EXP, FIN, OUT.
// Throughput: one item per cycle while the queue accepts; the back takes one
// vector at a time (serial chunk multiply plus 20 exp steps), two vectors queue.
// Reset: synchronous active low; clears sum and flag, gamma returns to 0.5.
// ----------------------------------------------------------------------------
module gaussian_rbf_kernel_unit #(
    parameter int ELEM_BITS = 16,
    parameter int ACC_BITS  = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    grbf_in_if.sink                           i_item,
    grbf_out_if.source                        o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [grbf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [grbf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [grbf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import grbf_pkg::*;

    logic [GAMMA_W-1:0]  r_gamma;
    logic                reg_sel;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    logic [ACC_BITS-1:0] f_sum;
    logic                f_sat;
    logic [ACC_BITS:0]   q_out;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_GAMMA;
    assign prdata  = reg_sel ? APB_DATA_W'(r_gamma) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_gamma <= pwdata[GAMMA_W-1:0];
        end
    end

    grbf_front #(
        .ELEM_BITS (ELEM_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (push),
        .o_sum   (f_sum),
        .o_sat   (f_sat)
    );

    grbf_queue #(
        .W (ACC_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_sat, f_sum}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    grbf_back #(
        .ELEM_BITS (ELEM_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gamma  (r_gamma),
        .i_empty  (q_empty),
        .i_sum    (q_out[ACC_BITS-1:0]),
        .i_sat    (q_out[ACC_BITS]),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// ===== src/grbf_front.sv =====
// ----------------------------------------------------------------------------
// grbf_front: squared distance accumulator
// Squares each element difference and adds it to a saturating sum; a vector
// end pushes the sum and its flag into the job queue.
// ----------------------------------------------------------------------------
module grbf_front #(
    parameter int ELEM_BITS = 16,
    parameter int ACC_BITS  = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    grbf_in_if.sink              i_item,
    input  logic                 i_full,
    output logic                 o_push,
    output logic [ACC_BITS-1:0]  o_sum,
    output logic                 o_sat
);
    localparam int SQ_W = 2 * ELEM_BITS;
    localparam int WIDE = ((SQ_W > ACC_BITS) ? SQ_W : ACC_BITS) + 1;

    logic                 r_a_valid;
    logic [SQ_W-1:0]      r_sq;
    logic                 r_last;
    logic [ACC_BITS-1:0]  r_sum;
    logic                 r_sat;

    logic signed [ELEM_BITS:0] diff;
    logic [ELEM_BITS:0]        absd;
    logic [ELEM_BITS-1:0]      mag;
    logic [SQ_W-1:0]           sq;
    logic                      accept;
    logic                      adv_b;

    logic [WIDE-1:0]     acc_max;
    logic [WIDE-1:0]     sq_w;
    logic [WIDE-1:0]     sq_clip;
    logic [WIDE-1:0]     tot;
    logic                clip;
    logic                ovf;
    logic [ACC_BITS-1:0] n_sum;
    logic                n_sat;

    assign diff   = {i_item.a_elem[ELEM_BITS-1], i_item.a_elem}
                  - {i_item.b_elem[ELEM_BITS-1], i_item.b_elem};
    assign absd   = diff[ELEM_BITS] ? (~diff + 1'b1) : diff;
    assign mag    = absd[ELEM_BITS-1:0];
    assign sq     = SQ_W'(mag) * SQ_W'(mag);

    assign adv_b        = r_a_valid & (~r_last | ~i_full);
    assign i_item.ready = ~r_a_valid | adv_b;
    assign accept       = i_item.valid & i_item.ready;

    assign acc_max = {{(WIDE - ACC_BITS){1'b0}}, {ACC_BITS{1'b1}}};
    assign sq_w    = WIDE'(r_sq);
    assign clip    = sq_w > acc_max;
    assign sq_clip = clip ? acc_max : sq_w;
    assign tot     = WIDE'(r_sum) + sq_clip;
    assign ovf     = tot > acc_max;
    assign n_sum   = ovf ? {ACC_BITS{1'b1}} : tot[ACC_BITS-1:0];
    assign n_sat   = r_sat | clip | ovf;

    assign o_push = adv_b & r_last;
    assign o_sum  = n_sum;
    assign o_sat  = n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sum     <= '0;
            r_sat     <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (adv_b) begin
                r_a_valid <= 1'b0;
            end
            if (adv_b) begin
                if (r_last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_sat <= n_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq   <= sq;
            r_last <= i_item.last;
        end
    end

endmodule

// ===== src/grbf_queue.sv =====
// ----------------------------------------------------------------------------
// grbf_queue: job queue
// Two-entry queue of finished distance sums between front and back.
// ----------------------------------------------------------------------------
module grbf_queue #(
    parameter int W = 49
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output logic          o_full,
    output logic          o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/grbf_back.sv =====
// ----------------------------------------------------------------------------
// grbf_back: kernel evaluation
// Scales a distance sum by gamma over 16-bit chunks, then builds the
// exponential with one table multiply per exponent bit.
// ----------------------------------------------------------------------------
module grbf_back #(
    parameter int ELEM_BITS = 16,
    parameter int ACC_BITS  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [grbf_pkg::GAMMA_W-1:0]  i_gamma,
    input  logic                          i_empty,
    input  logic [ACC_BITS-1:0]           i_sum,
    input  logic                          i_sat,
    output logic                          o_pop,
    grbf_out_if.source                    o_result
);
    import grbf_pkg::*;

    localparam int FRAC_SQ = 2 * (ELEM_BITS - 4);
    localparam int NCH     = (ACC_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD     = NCH * CHUNK_W;
    localparam int PW_A    = PAD + GAMMA_W;
    localparam int PW_B    = FRAC_SQ + T_W;
    localparam int PW      = ((PW_A > PW_B) ? PW_A : PW_B) + 1;
    localparam int EP_W    = P_W + FACTOR_W;

    t_back_state r_state;
    t_back_state n_state;

    logic [PAD-1:0]        r_shift;
    logic [PW-1:0]         r_prod;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [T_W-1:0]        r_t;
    logic [P_W-1:0]        r_p;
    logic                  r_sat;
    logic                  r_zero;
    logic [KERNEL_W-1:0]   r_kernel;

    logic [CHUNK_W+GAMMA_W-1:0] chunk_prod;
    logic [EP_W-1:0]            exp_prod;
    logic [EP_W-1:0]            exp_rnd;
    logic [P_W-1:0]             kr;
    logic                       mul_done;
    logic                       exp_done;

    assign chunk_prod = (CHUNK_W+GAMMA_W)'(r_shift[PAD-1 -: CHUNK_W])
                      * (CHUNK_W+GAMMA_W)'(i_gamma);
    assign exp_prod   = EP_W'(r_p) * EP_W'(exp_factor(r_cnt));
    assign exp_rnd    = exp_prod + (EP_W'(1) << (FACTOR_W - 1));
    assign kr         = r_p + P_W'(256);
    assign mul_done   = r_cnt == STEP_CNT_W'(NCH - 1);
    assign exp_done   = r_cnt == STEP_CNT_W'(EXP_STEPS - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = S_MUL;
            S_MUL:   if (mul_done) n_state = S_SCALE;
            S_SCALE: n_state = S_EXP;
            S_EXP:   if (exp_done) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == S_IDLE) & ~i_empty;
        o_result.valid = r_state == S_OUT;
    end

    assign o_result.kernel_value = r_kernel;
    assign o_result.saturated    = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_shift <= PAD'(i_sum);
                r_sat   <= i_sat;
                r_prod  <= '0;
                r_cnt   <= '0;
            end
            S_MUL: begin
                r_prod  <= (r_prod << CHUNK_W) + PW'(chunk_prod);
                r_shift <= r_shift << CHUNK_W;
                r_cnt   <= r_cnt + 1'b1;
            end
            S_SCALE: begin
                r_zero <= |r_prod[PW-1:FRAC_SQ+T_W];
                r_t    <= r_prod[FRAC_SQ+T_W-1:FRAC_SQ];
                r_p    <= Q24_ONE;
                r_cnt  <= '0;
            end
            S_EXP: begin
                if (r_t[T_W-1]) begin
                    r_p <= exp_rnd[EP_W-1:FACTOR_W];
                end
                r_t   <= r_t << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIN: begin
                r_kernel <= r_zero ? '0 : kr[P_W-1:9];
            end
            default: begin
            end
        endcase
    end

endmodule
